FILE: rtl/core/fup_pkg.sv
// ----------------------------------------------------------------------------
// fup_pkg
// Types, character codes and the hex digit decoder for the form-urlencoded
// parser.
// ----------------------------------------------------------------------------
package fup_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_FIRST = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } fup_in_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       in_value;
    logic       key_end;
    logic       pair_end;
    logic       pair_has_value;
    logic       pair_error;
    logic       last_out;
  } fup_out_t;

  // One queue entry: the results caused by one input byte (one or two).
  typedef struct packed {
    logic     two;
    fup_out_t res0;
    fup_out_t res1;
  } fup_entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } fup_hex_t;

  function automatic fup_hex_t hex_decode(input logic [7:0] c);
    fup_hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: rtl/core/form_urlencoded_parser.sv
// ----------------------------------------------------------------------------
// form_urlencoded_parser
// Streaming decoder for form-urlencoded strings, one raw byte per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one raw byte with a flag on the
// final byte of the string. Output channel (out_valid/out_ready/out_data):
// decoded key and value bytes, key-end marks and pair-end marks, in order.
// A byte causes zero, one or two results.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver does not stall; a byte causing two results (a final byte
// that also yields a byte or key end, or '&' on the final byte) takes the
// output register for both results, since it moves one result per cycle.
// The queue entry is written at the edge that accepts the byte, and the
// output register loads it from the queue head when it is empty or drained;
// a result is offered from the output register, not straight from the queue.
// The front updates its pair state as each byte is accepted; a queue of
// QUEUE_DEPTH entries parts it from the output sequencer, so in_ready drops
// only when the queue is full. When the receiver stalls, results hold in the
// output register and queue, and input keeps flowing until the queue fills.
// Reset clears the pair state, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module form_urlencoded_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fup_pkg::fup_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fup_pkg::fup_out_t out_data
);
  import fup_pkg::*;

  logic       q_ready, q_push, q_pop, q_head_valid;
  fup_entry_t q_data, q_head;

  fup_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  fup_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_data),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  fup_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A final byte always ends a pair, so it must leave an entry behind.
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last) |-> (q_push && (q_data.two ?
      q_data.res1.last_out : q_data.res0.last_out)))
    else $error("final byte produced no closing result");

  // An ampersand always reports the pair it closes first.
  a_amp_pair_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.in_byte == CH_AMP) |->
      (q_push && q_data.res0.pair_end))
    else $error("ampersand did not close the pair");

  // A waiting entry reaches an empty output register in the next cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (q_head_valid && !out_valid) |=> out_valid)
    else $error("queue entry not moved to output");

endmodule

FILE: rtl/core/fup_front.sv
// ----------------------------------------------------------------------------
// fup_front
// Accepts raw bytes, tracks key/value and escape state, and builds the queue
// entry holding the results that each byte causes.
// ----------------------------------------------------------------------------
module fup_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fup_pkg::fup_in_t    in_data,
  input  logic                q_ready,
  output logic                q_push,
  output fup_pkg::fup_entry_t q_data
);
  import fup_pkg::*;

  logic       value_mode_r, value_mode_nxt;
  logic [1:0] escape_phase_r, escape_phase_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       pair_failed_r, pair_failed_nxt;

  logic       accept;
  logic       has_a;
  fup_out_t   res_a;
  fup_out_t   res_fin;
  fup_hex_t   hx;
  fup_entry_t ent;
  logic       want_push;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    value_mode_nxt   = value_mode_r;
    escape_phase_nxt = (escape_phase_r > ESC_SECOND) ? ESC_NONE : escape_phase_r;
    high_nibble_nxt  = high_nibble_r;
    pair_failed_nxt  = pair_failed_r;
    hx      = hex_decode(in_data.in_byte);
    has_a   = 1'b0;
    res_a   = '0;
    res_fin = '0;
    ent     = '0;
    want_push = 1'b0;

    if (in_data.in_byte == CH_AMP) begin
      res_a.pair_end       = 1'b1;
      res_a.pair_has_value = value_mode_nxt;
      res_a.pair_error     = pair_failed_nxt || (escape_phase_nxt != ESC_NONE);
      res_fin.pair_end = 1'b1;
      res_fin.last_out = 1'b1;
      ent.res0  = res_a;
      ent.res1  = res_fin;
      ent.two   = in_data.last;
      want_push = 1'b1;
      value_mode_nxt   = 1'b0;
      escape_phase_nxt = ESC_NONE;
      high_nibble_nxt  = 4'd0;
      pair_failed_nxt  = 1'b0;
    end else begin
      if (pair_failed_nxt) begin
        // drop bytes until the pair ends
      end else if (escape_phase_nxt == ESC_FIRST) begin
        if (!hx.ok) begin
          pair_failed_nxt  = 1'b1;
          escape_phase_nxt = ESC_NONE;
        end else begin
          high_nibble_nxt  = hx.nib;
          escape_phase_nxt = ESC_SECOND;
        end
      end else if (escape_phase_nxt == ESC_SECOND) begin
        escape_phase_nxt = ESC_NONE;
        if (!hx.ok) begin
          pair_failed_nxt = 1'b1;
        end else begin
          has_a          = 1'b1;
          res_a.has_byte = 1'b1;
          res_a.out_byte = {high_nibble_r, hx.nib};
          res_a.in_value = value_mode_nxt;
        end
        high_nibble_nxt = 4'd0;
      end else if (in_data.in_byte == CH_PCT) begin
        escape_phase_nxt = ESC_FIRST;
      end else if (in_data.in_byte == CH_EQ && !value_mode_nxt) begin
        value_mode_nxt = 1'b1;
        has_a          = 1'b1;
        res_a.key_end  = 1'b1;
      end else begin
        has_a          = 1'b1;
        res_a.has_byte = 1'b1;
        res_a.out_byte = (in_data.in_byte == CH_PLUS) ? CH_SPACE : in_data.in_byte;
        res_a.in_value = value_mode_nxt;
      end

      res_fin.pair_end       = 1'b1;
      res_fin.pair_has_value = value_mode_nxt;
      res_fin.pair_error     = pair_failed_nxt || (escape_phase_nxt != ESC_NONE);
      res_fin.last_out       = 1'b1;

      if (has_a) begin
        ent.res0 = res_a;
        ent.res1 = res_fin;
        ent.two  = in_data.last;
      end else begin
        ent.res0 = res_fin;
        ent.two  = 1'b0;
      end
      want_push = has_a || in_data.last;

      if (in_data.last) begin
        value_mode_nxt   = 1'b0;
        escape_phase_nxt = ESC_NONE;
        high_nibble_nxt  = 4'd0;
        pair_failed_nxt  = 1'b0;
      end
    end
  end

  assign q_push = accept && want_push;
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_mode_r   <= 1'b0;
      escape_phase_r <= ESC_NONE;
      high_nibble_r  <= 4'd0;
      pair_failed_r  <= 1'b0;
    end else if (accept) begin
      value_mode_r   <= value_mode_nxt;
      escape_phase_r <= escape_phase_nxt;
      high_nibble_r  <= high_nibble_nxt;
      pair_failed_r  <= pair_failed_nxt;
    end
  end

endmodule

FILE: rtl/core/fup_fifo.sv
// ----------------------------------------------------------------------------
// fup_fifo
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module fup_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                push_ready,
  input  fup_pkg::fup_entry_t push_data,
  input  logic                pop,
  output logic                head_valid,
  output fup_pkg::fup_entry_t head_data
);
  import fup_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fup_entry_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/fup_back.sv
// ----------------------------------------------------------------------------
// fup_back
// Takes queue entries and hands their results, one per transfer, to the
// output register.
// ----------------------------------------------------------------------------
module fup_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  fup_pkg::fup_entry_t head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fup_pkg::fup_out_t   out_data
);
  import fup_pkg::*;

  typedef enum logic {PH_FIRST, PH_SECOND} phase_t;

  phase_t   phase_r, phase_nxt;
  logic     out_valid_r, out_valid_nxt;
  fup_out_t out_data_r, out_data_nxt;
  logic     load;

  // Refill the output register when it is empty or being drained.
  assign load = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        case (phase_r)
          PH_FIRST: begin
            out_data_nxt = head_data.res0;
            if (head_data.two) begin
              phase_nxt = PH_SECOND;
            end else begin
              pop = 1'b1;
            end
          end
          PH_SECOND: begin
            out_data_nxt = head_data.res1;
            phase_nxt    = PH_FIRST;
            pop          = 1'b1;
          end
          default: begin
            phase_nxt = PH_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
